// ===== sv/rlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpd_pkg
// Shared constants, codes and types of the raster local peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpd_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 8;

	// Fixed widths of the configuration data and the result fields.
	localparam int CFG_W   = 11;
	localparam int VALUE_W = 8;
	localparam int POS_W   = 10;

	// Frame size after reset and the smallest usable frame side.
	localparam int RESET_WIDTH  = 20;
	localparam int RESET_HEIGHT = 20;
	localparam int MIN_DIM      = 2;

	// Queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	// Queue status seen by both sides.
	typedef struct packed {
		logic               empty;
		logic [LEVEL_W-1:0] level;
	} fifo_stat_t;

	// Which results a queued run holds and their peak flags.
	typedef struct packed {
		logic has_left;
		logic has_last;
		logic peak_upper;
		logic peak_left;
		logic peak_last;
	} run_ctl_t;

	// Position class of an accepted pixel.
	typedef struct packed {
		logic r_zero;
		logic r_ge2;
		logic r_last;
		logic c_zero;
		logic c_gt1;
		logic c_last;
	} pos_flags_t;

	// Result slot of a run: pixel above, left neighbour in the last row,
	// and the frame's final pixel.
	typedef enum logic [1:0] {
		SLOT_UPPER,
		SLOT_LEFT,
		SLOT_LAST
	} slot_t;

endpackage

`default_nettype wire

// ===== sv/rlpd_fifo.sv =====
// ----------------------------------------------------------------------------
// rlpd_fifo
// Short register queue that holds classified runs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpd_fifo
	import rlpd_pkg::*;
#(
	parameter int WIDTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output fifo_stat_t            stat
);

	logic [WIDTH-1:0]   mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0] count_q;

	// Storage; the writer never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + LEVEL_W'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - LEVEL_W'(1);
			end
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.level = count_q;

endmodule

`default_nettype wire

// ===== sv/rlpd_front.sv =====
// ----------------------------------------------------------------------------
// rlpd_front
// Accepts pixels, keeps the frame position and the two line stores, and
// classifies each pixel into a run of up to three results for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpd_front
	import rlpd_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int CW        = $clog2(MAX_WIDTH),
	localparam int RW        = $clog2(MAX_HEIGHT),
	localparam int RUN_W     = RW + CW + 3 * PIXEL_BITS + $bits(run_ctl_t)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  push,
	input  wire logic [PIXEL_BITS-1:0] pixel_value,
	output logic                       full,
	input  wire fifo_stat_t            fstat,
	output logic                       q_push,
	output logic      [RUN_W-1:0]      q_data
);

	localparam int WD_W  = $clog2(MAX_WIDTH + 1);
	localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	// Frame size, position, the last pixels of the current row and a previous-row pixel.
	logic [WD_W-1:0]       width_q;
	logic [HD_W-1:0]       height_q;
	logic [RW-1:0]         row_q;
	logic [CW-1:0]         col_q;
	logic [PIXEL_BITS-1:0] left0_q;
	logic [PIXEL_BITS-1:0] left1_q;
	logic [PIXEL_BITS-1:0] prev_left_q;

	// Line stores: newer holds the previous row, older the row above it.
	logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];

	// Classification stage.
	logic                  v_s1;
	pos_flags_t            flags_s1;
	logic [RW-1:0]         row_s1;
	logic [CW-1:0]         col_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [PIXEL_BITS-1:0] left0_s1;
	logic [PIXEL_BITS-1:0] left1_s1;
	logic [PIXEL_BITS-1:0] mid_s1;
	logic [PIXEL_BITS-1:0] right_s1;
	logic [PIXEL_BITS-1:0] up_s1;

	logic                  accept;
	pos_flags_t            flags;
	logic [CW-1:0]         right_addr;
	logic [WD_W-1:0]       cfg_w;
	logic [HD_W-1:0]       cfg_h;
	logic [PIXEL_BITS-1:0] left_up;
	logic [PIXEL_BITS-1:0] right_up;
	logic [PIXEL_BITS-1:0] above_up;
	logic [PIXEL_BITS-1:0] left_last;
	run_ctl_t              ctl;

	// Room for this beat and the one still in the classification stage.
	assign full   = (fstat.level + LEVEL_W'(v_s1)) >= LEVEL_W'(QUEUE_DEPTH);
	assign accept = push && !full;

	// Position class of the next pixel.
	always_comb begin
		flags.r_zero = (row_q == '0);
		flags.r_ge2  = (row_q != '0) && (row_q != RW'(1));
		flags.r_last = (HD_W'(row_q) + HD_W'(1)) == height_q;
		flags.c_zero = (col_q == '0);
		flags.c_gt1  = (col_q != '0) && (col_q != CW'(1));
		flags.c_last = (WD_W'(col_q) + WD_W'(1)) == width_q;
	end

	assign right_addr = flags.c_last ? '0 : col_q + CW'(1);

	// Written sizes are held to the usable range.
	always_comb begin
		if (cfg_data < CFG_W'(MIN_DIM)) begin
			cfg_w = WD_W'(MIN_DIM);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			cfg_w = WD_W'(MAX_WIDTH);
		end else begin
			cfg_w = WD_W'(cfg_data);
		end
		if (cfg_data < CFG_W'(MIN_DIM)) begin
			cfg_h = HD_W'(MIN_DIM);
		end else if (32'(cfg_data) > MAX_HEIGHT) begin
			cfg_h = HD_W'(MAX_HEIGHT);
		end else begin
			cfg_h = HD_W'(cfg_data);
		end
	end

	// Size registers and raster position; any write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WD_W'(RST_W);
			height_q <= HD_W'(RST_H);
			row_q    <= '0;
			col_q    <= '0;
			left0_q  <= '0;
			left1_q  <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_IDX_WIDTH:  width_q  <= cfg_w;
					CFG_IDX_HEIGHT: height_q <= cfg_h;
					default: ;
				endcase
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (flags.c_last) begin
					col_q <= '0;
					row_q <= flags.r_last ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (accept) begin
				left1_q <= left0_q;
				left0_q <= pixel_value;
			end
		end
	end

	// Newer row store: read the column and its right neighbour, then replace.
	always_ff @(posedge clk) begin
		if (accept) begin
			newer_mem[col_q] <= pixel_value;
			mid_s1           <= newer_mem[col_q];
			right_s1         <= newer_mem[right_addr];
		end
	end

	// Older row store: read on accept, written with the rotated pixel a beat later.
	always_ff @(posedge clk) begin
		if (v_s1 && !flags_s1.r_zero) begin
			older_mem[col_s1] <= mid_s1;
		end
		if (accept) begin
			up_s1 <= older_mem[col_q];
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
			row_s1   <= row_q;
			col_s1   <= col_q;
			px_s1    <= pixel_value;
			left0_s1 <= left0_q;
			left1_s1 <= left1_q;
		end
	end

	// Stage valid and the previous-row pixel left of the current column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			prev_left_q <= '0;
		end else begin
			v_s1 <= accept;
			if (v_s1 && !flags_s1.r_zero) begin
				prev_left_q <= mid_s1;
			end
		end
	end

	// Neighbours of the pixel above and of the left result; a missing one takes the opposite side.
	always_comb begin
		left_up   = flags_s1.c_zero ? right_s1 : prev_left_q;
		right_up  = flags_s1.c_last ? left_up : right_s1;
		above_up  = flags_s1.r_ge2 ? up_s1 : px_s1;
		left_last = flags_s1.c_gt1 ? left1_s1 : px_s1;
	end

	// Peak decisions for the three possible results of this pixel.
	always_comb begin
		ctl.has_left   = flags_s1.r_last && !flags_s1.c_zero;
		ctl.has_last   = flags_s1.r_last && flags_s1.c_last;
		ctl.peak_upper = (mid_s1 > left_up) && (mid_s1 > right_up) &&
		                 (mid_s1 > above_up) && (mid_s1 > px_s1);
		ctl.peak_left  = (left0_s1 > left_last) && (left0_s1 > px_s1) &&
		                 (left0_s1 > prev_left_q);
		ctl.peak_last  = (px_s1 > left0_s1) && (px_s1 > mid_s1);
	end

	assign q_push = v_s1 && !flags_s1.r_zero;
	assign q_data = {row_s1, col_s1, mid_s1, left0_s1, px_s1, ctl};

endmodule

`default_nettype wire

// ===== sv/rlpd_back.sv =====
// ----------------------------------------------------------------------------
// rlpd_back
// Takes queued runs apart into single results and holds each in the output
// register until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpd_back
	import rlpd_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int CW        = $clog2(MAX_WIDTH),
	localparam int RW        = $clog2(MAX_HEIGHT),
	localparam int RUN_W     = RW + CW + 3 * PIXEL_BITS + $bits(run_ctl_t)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire fifo_stat_t            fstat,
	input  wire logic [RUN_W-1:0]      q_data,
	output logic                       q_pop,
	output logic                       empty,
	input  wire logic                  pop,
	output logic      [PIXEL_BITS-1:0] out_value,
	output logic      [POS_W-1:0]      out_row,
	output logic      [POS_W-1:0]      out_column,
	output logic                       is_peak,
	output logic                       last_of_run,
	output logic                       end_of_frame
);

	slot_t                 slot_q;
	slot_t                 slot_d;
	slot_t                 slot_next;

	logic [RW-1:0]         h_row;
	logic [CW-1:0]         h_col;
	logic [PIXEL_BITS-1:0] h_upper;
	logic [PIXEL_BITS-1:0] h_left;
	logic [PIXEL_BITS-1:0] h_last;
	run_ctl_t              h_ctl;

	logic [PIXEL_BITS-1:0] sel_value;
	logic [RW-1:0]         sel_row;
	logic [CW-1:0]         sel_col;
	logic                  sel_peak;
	logic                  sel_end;
	logic                  sel_eof;
	logic                  load;

	logic                  out_v_q;
	logic [PIXEL_BITS-1:0] value_q;
	logic [RW-1:0]         row_q;
	logic [CW-1:0]         col_q;
	logic                  peak_q;
	logic                  end_q;
	logic                  eof_q;

	assign {h_row, h_col, h_upper, h_left, h_last, h_ctl} = q_data;

	// Load a new beat whenever the queue holds a run and the output register is free or being popped.
	assign load  = !fstat.empty && (!out_v_q || pop);
	assign q_pop = load && sel_end;

	// Slot sequencer: pick the current result of the head run.
	always_comb begin
		sel_value = h_upper;
		sel_row   = h_row - RW'(1);
		sel_col   = h_col;
		sel_peak  = h_ctl.peak_upper;
		sel_end   = 1'b1;
		sel_eof   = 1'b0;
		slot_next = SLOT_UPPER;
		case (slot_q)
			SLOT_UPPER: begin
				sel_end   = !h_ctl.has_left && !h_ctl.has_last;
				slot_next = h_ctl.has_left ? SLOT_LEFT : SLOT_LAST;
			end
			SLOT_LEFT: begin
				sel_value = h_left;
				sel_row   = h_row;
				sel_col   = h_col - CW'(1);
				sel_peak  = h_ctl.peak_left;
				sel_end   = !h_ctl.has_last;
				slot_next = SLOT_LAST;
			end
			SLOT_LAST: begin
				sel_value = h_last;
				sel_row   = h_row;
				sel_peak  = h_ctl.peak_last;
				sel_eof   = 1'b1;
			end
			default: ;
		endcase
		slot_d = slot_q;
		if (load) begin
			slot_d = sel_end ? SLOT_UPPER : slot_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_UPPER;
		end else begin
			slot_q <= slot_d;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= sel_value;
			row_q   <= sel_row;
			col_q   <= sel_col;
			peak_q  <= sel_peak;
			end_q   <= sel_end;
			eof_q   <= sel_eof;
		end
	end

	assign empty        = !out_v_q;
	assign out_value    = value_q;
	assign out_row      = POS_W'(row_q);
	assign out_column   = POS_W'(col_q);
	assign is_peak      = peak_q;
	assign last_of_run  = end_q;
	assign end_of_frame = eof_q;

endmodule

`default_nettype wire

// ===== sv/raster_local_peak_detector_unit.sv =====
// ----------------------------------------------------------------------------
// raster_local_peak_detector_unit
// Four-neighbour local maximum detector over a raster pixel stream.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  -----------------------------------------------
//  pixels    push / full        pixel_value
//  results   empty / pop        out_value, out_row, out_column, is_peak,
//                               last_of_run, end_of_frame
//  config    cfg_write          cfg_index, cfg_data (frame_width, frame_height)
//
// One pixel is taken per clock while full is low; pixels of the frame's last
// row after its first give two results each (three for the final pixel), and
// the single result port then sets the pace. A pixel beat's first result passes
// the classification stage and the run queue before it reaches the output
// register. The line stores are single-write memories of MAX_WIDTH entries and
// need no clearing after reset. A stalled result side fills the four-run queue
// and then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_local_peak_detector_unit
	import rlpd_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [PIXEL_BITS-1:0] pixel_value,
	output logic                       empty,
	input  wire logic                  pop,
	output logic      [PIXEL_BITS-1:0] out_value,
	output logic      [POS_W-1:0]      out_row,
	output logic      [POS_W-1:0]      out_column,
	output logic                       is_peak,
	output logic                       last_of_run,
	output logic                       end_of_frame
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int RUN_W = RW + CW + 3 * PIXEL_BITS + $bits(run_ctl_t);

	fifo_stat_t       fstat;
	logic             q_push;
	logic             q_pop;
	logic [RUN_W-1:0] q_wdata;
	logic [RUN_W-1:0] q_rdata;

	// Front: position, line stores and classification.
	rlpd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.pixel_value (pixel_value),
		.full        (full),
		.fstat       (fstat),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	// Queue of classified runs.
	rlpd_fifo #(
		.WIDTH (RUN_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.stat    (fstat)
	);

	// Back: one result per beat from the head run.
	rlpd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fstat        (fstat),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.out_value    (out_value),
		.out_row      (out_row),
		.out_column   (out_column),
		.is_peak      (is_peak),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

endmodule

`default_nettype wire

// ===== sv/rlpd_checker.sv =====
// ----------------------------------------------------------------------------
// rlpd_checker
// Port-level checks on the result side of the peak detector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpd_checker
	import rlpd_pkg::*;
#(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire logic [PIXEL_BITS-1:0] out_value,
	input wire logic [POS_W-1:0]      out_row,
	input wire logic [POS_W-1:0]      out_column,
	input wire logic                  is_peak,
	input wire logic                  last_of_run,
	input wire logic                  end_of_frame
);

	// A waiting result beat holds still until it is popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_value) && $stable(out_row) &&
		$stable(out_column) && $stable(is_peak) && $stable(last_of_run) &&
		$stable(end_of_frame))
		else $error("result beat changed while waiting");

	// The frame's final result always closes its run.
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && end_of_frame |-> last_of_run)
		else $error("end of frame without end of run");

	// The rest of a run is already queued, so it follows without a gap.
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_run |=> !empty)
		else $error("gap inside a run of results");

	// Inside a run the row stays or rises by one.
	a_run_rows: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_run |=>
		(out_row == $past(out_row)) || (out_row == $past(out_row) + POS_W'(1)))
		else $error("row jump inside a run of results");

endmodule

bind raster_local_peak_detector_unit rlpd_checker #(
	.PIXEL_BITS (PIXEL_BITS)
) u_rlpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.out_value    (out_value),
	.out_row      (out_row),
	.out_column   (out_column),
	.is_peak      (is_peak),
	.last_of_run  (last_of_run),
	.end_of_frame (end_of_frame)
);

`default_nettype wire
